// ----- hw/rtl/dst_pkg.sv -----
package dst_pkg;

  // Default sizes for the top level parameters.
  localparam int MAX_SLEEPERS_DEF = 16;
  localparam int TIME_BITS_DEF    = 48;

  // Operation codes on the request channel.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SLEEP = 1'b1;

  // Status codes on the response channel.
  localparam logic ST_WOKEN  = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  // One request item.
  typedef struct packed {
    logic        op;
    logic [7:0]  task_id;
    logic [31:0] ticks;
  } req_t;

  // One response item.
  typedef struct packed {
    logic [7:0] woken_task;
    logic       status;
    logic       last;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;
    logic reject;
    logic tick;
    logic step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/dst_ctrl.sv -----
module dst_ctrl #(
  parameter int MAX_SLEEPERS = dst_pkg::MAX_SLEEPERS_DEF,
  localparam int CNT_W = $clog2(MAX_SLEEPERS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  dst_pkg::req_t      req,
  input  dst_pkg::sts_t      sts,
  input  logic [CNT_W-1:0]   len,
  output dst_pkg::cmd_t      cmd
);
  import dst_pkg::*;

  typedef enum logic {
    IDLE,
    SCAN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] steps;

  // Decode the request and sequence the scan.
  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    case (state)
      IDLE: begin
        req_stall = !sts.out_free;
        if (req_valid && sts.out_free) begin
          if (req.op == OP_TICK) begin
            cmd.tick = 1'b1;
          end else if (req.ticks != 32'd0) begin
            if (sts.full) begin
              cmd.reject = 1'b1;
            end else begin
              cmd.insert = 1'b1;
            end
          end
        end
      end
      SCAN: begin
        if (sts.out_free) begin
          if (steps == '0) begin
            cmd.finish = 1'b1;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        cmd       = '0;
        req_stall = 1'b1;
      end
    endcase
  end

  // State and remaining scan count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      steps <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.tick) begin
            state <= SCAN;
            steps <= len;
          end
        end
        SCAN: begin
          if (cmd.finish) begin
            state <= IDLE;
          end else if (cmd.step) begin
            steps <= steps - 1'b1;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/dst_datapath.sv -----
module dst_datapath #(
  parameter int MAX_SLEEPERS = dst_pkg::MAX_SLEEPERS_DEF,
  parameter int TIME_BITS    = dst_pkg::TIME_BITS_DEF,
  localparam int CNT_W = $clog2(MAX_SLEEPERS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  dst_pkg::req_t    req,
  input  dst_pkg::cmd_t    cmd,
  output dst_pkg::sts_t    sts,
  output logic [CNT_W-1:0] len,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output dst_pkg::rsp_t    rsp
);
  import dst_pkg::*;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Table kept as a queue: slot 0 is the head, len slots are occupied.
  logic [7:0]           slot_task     [MAX_SLEEPERS];
  logic [TIME_BITS-1:0] slot_deadline [MAX_SLEEPERS];
  logic [TIME_BITS-1:0] now_count;
  logic                 pend_valid;
  logic [7:0]           pend_task;

  logic [TIME_BITS:0]   dl_sum;
  logic [TIME_BITS-1:0] deadline;
  logic                 head_due;
  logic                 push;
  rsp_t                 push_item;

  // Saturating deadline for a new sleeper.
  assign dl_sum   = {1'b0, now_count} + {{(TIME_BITS - 31){1'b0}}, req.ticks};
  assign deadline = dl_sum[TIME_BITS] ? TIME_MAX : dl_sum[TIME_BITS-1:0];

  assign head_due = slot_deadline[0] <= now_count;

  assign sts.full     = len == CNT_W'(MAX_SLEEPERS);
  assign sts.out_free = !rsp_valid || !rsp_stall;

  // Select what goes into the output register this cycle.
  always_comb begin
    push      = 1'b0;
    push_item = '0;
    if (cmd.reject) begin
      push                 = 1'b1;
      push_item.woken_task = req.task_id;
      push_item.status     = ST_REJECT;
      push_item.last       = 1'b1;
    end else if (cmd.step && head_due && pend_valid) begin
      push                 = 1'b1;
      push_item.woken_task = pend_task;
      push_item.status     = ST_WOKEN;
      push_item.last       = 1'b0;
    end else if (cmd.finish && pend_valid) begin
      push                 = 1'b1;
      push_item.woken_task = pend_task;
      push_item.status     = ST_WOKEN;
      push_item.last       = 1'b1;
    end
  end

  // Control registers: fill count, tick count, pending and output flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      len        <= '0;
      now_count  <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.insert) begin
        len <= len + 1'b1;
      end else if (cmd.step && head_due) begin
        len <= len - 1'b1;
      end
      if (cmd.tick && now_count != TIME_MAX) begin
        now_count <= now_count + 1'b1;
      end
      if (cmd.step && head_due) begin
        pend_valid <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid <= 1'b0;
      end
      if (push) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (push) begin
      rsp <= push_item;
    end
    if (cmd.step && head_due) begin
      pend_task <= slot_task[0];
    end
  end

  // Table shifts: insert at the head, or pop the head and requeue it at
  // the tail when it is not yet due.
  for (genvar i = 0; i < MAX_SLEEPERS; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (cmd.insert) begin
        if (i == 0) begin
          slot_task[i]     <= req.task_id;
          slot_deadline[i] <= deadline;
        end else begin
          slot_task[i]     <= slot_task[(i > 0) ? i - 1 : 0];
          slot_deadline[i] <= slot_deadline[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.step) begin
        if (!head_due && CNT_W'(i) == len - 1'b1) begin
          slot_task[i]     <= slot_task[0];
          slot_deadline[i] <= slot_deadline[0];
        end else if (i < MAX_SLEEPERS - 1) begin
          slot_task[i]     <= slot_task[(i < MAX_SLEEPERS - 1) ? i + 1 : i];
          slot_deadline[i] <= slot_deadline[(i < MAX_SLEEPERS - 1) ? i + 1 : i];
        end
      end
    end
  end

endmodule

// ----- hw/rtl/deadline_sleep_table.sv -----
// Sleep table with a saturating tick counter. A sleep request with nonzero
// ticks stores the task with deadline now plus ticks; when the table is full
// it returns one response with the reject status. A tick request advances
// the count, then scans the occupied slots one per cycle, while the response
// side does not stall, through a single deadline compare. Woken tasks come
// out newest first, and the final response of a tick carries last.
module deadline_sleep_table #(
  parameter int MAX_SLEEPERS = dst_pkg::MAX_SLEEPERS_DEF,
  parameter int TIME_BITS    = dst_pkg::TIME_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dst_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output dst_pkg::rsp_t rsp
);
  import dst_pkg::*;

  localparam int CNT_W = $clog2(MAX_SLEEPERS + 1);

  cmd_t             cmd;
  sts_t             sts;
  logic [CNT_W-1:0] len;

  dst_ctrl #(
    .MAX_SLEEPERS(MAX_SLEEPERS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .sts       (sts),
    .len       (len),
    .cmd       (cmd)
  );

  dst_datapath #(
    .MAX_SLEEPERS(MAX_SLEEPERS),
    .TIME_BITS   (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .len       (len),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- sim/deadline_sleep_table_tb.sv -----
module deadline_sleep_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dst_pkg::*;

  localparam int SLOTS = MAX_SLEEPERS_DEF;
  localparam int TW = TIME_BITS_DEF;
  localparam logic [TW-1:0] TIME_TOP = '1;
  localparam int RANDOM_ITEMS = 165;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
  localparam int CYCLE_LIMIT = 300000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Shadow copy of the sleep table, kept in step with accepted requests.
  logic [TW-1:0] now_tick = '0;
  logic [7:0]    sleeper_task[SLOTS];
  logic [TW-1:0] sleeper_due[SLOTS];
  int            sleeper_count = 0;
  rsp_t          pending_wakes[$];

  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  deadline_sleep_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Addition that clamps at the largest representable tick count.
  function automatic logic [TW-1:0] clamp_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TW] ? TIME_TOP : sum[TW-1:0];
  endfunction

  // Apply one accepted request to the shadow table and queue the responses it causes.
  function automatic void advance_table(input req_t r);
    int   kept;
    rsp_t res;
    rsp_t woken[$];
    if (r.op == OP_SLEEP) begin
      if (r.ticks == 32'd0) return;
      if (sleeper_count >= SLOTS) begin
        res.woken_task = r.task_id;
        res.status     = ST_REJECT;
        res.last       = 1'b1;
        pending_wakes.push_back(res);
        return;
      end
      for (int i = sleeper_count; i > 0; i--) begin
        sleeper_task[i] = sleeper_task[i-1];
        sleeper_due[i]  = sleeper_due[i-1];
      end
      sleeper_task[0] = r.task_id;
      sleeper_due[0]  = clamp_add(now_tick, TW'(r.ticks));
      sleeper_count++;
      return;
    end
    now_tick = clamp_add(now_tick, TW'(1));
    kept = 0;
    for (int i = 0; i < sleeper_count; i++) begin
      if (sleeper_due[i] <= now_tick) begin
        res.woken_task = sleeper_task[i];
        res.status     = ST_WOKEN;
        res.last       = 1'b0;
        woken.push_back(res);
      end else begin
        sleeper_task[kept] = sleeper_task[i];
        sleeper_due[kept]  = sleeper_due[i];
        kept++;
      end
    end
    sleeper_count = kept;
    if (woken.size() != 0) woken[woken.size()-1].last = 1'b1;
    foreach (woken[i]) pending_wakes.push_back(woken[i]);
  endfunction

  function automatic req_t sleep_item(input logic [7:0] id, input logic [31:0] len);
    req_t r;
    r.op      = OP_SLEEP;
    r.task_id = id;
    r.ticks   = len;
    return r;
  endfunction

  // Tick requests carry random junk in the fields the block must ignore.
  function automatic req_t tick_item();
    req_t r;
    r.op      = OP_TICK;
    r.task_id = 8'($urandom);
    r.ticks   = $urandom;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  // Offer one request and wait for its transfer. Called and returns at a falling edge.
  // The sender works in bursts, idling for a random gap between them.
  task automatic send_req(input req_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    advance_table(item);
    @(negedge clk);
  endtask

  // Stop offering and let every expected response arrive, then let any scan finish.
  task automatic wait_for_idle();
    req_valid <= 1'b0;
    while (pending_wakes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic test_idle_tick();
    send_req(tick_item());
  endtask

  task automatic test_zero_ticks();
    send_req(sleep_item(8'hFF, 32'd0));
  endtask

  // Two tasks due on the same tick come out newest first, the older one carrying last.
  task automatic test_wake_order();
    send_req(sleep_item(8'h11, 32'd2));
    send_req(sleep_item(8'h22, 32'd1));
    send_req(sleep_item(8'h33, 32'd1));
    send_req(tick_item());
    send_req(tick_item());
  endtask

  // Fill every slot, have one more sleep rejected, then wake the whole table at once.
  task automatic test_full_table();
    for (int i = 0; i < SLOTS; i++) send_req(sleep_item(8'(i * 17), 32'd1));
    send_req(sleep_item(8'hA5, 32'd3));
    send_req(tick_item());
  endtask

  // The longest sleep never comes due in this run and keeps its slot.
  task automatic test_far_deadline();
    req_t r;
    send_req(sleep_item(8'hFF, 32'hFFFF_FFFF));
    r.op      = OP_TICK;
    r.task_id = 8'hFF;
    r.ticks   = 32'hFFFF_FFFF;
    send_req(r);
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) send_req(sleep_item(8'($urandom), 32'd1));
    send_req(tick_item());
    for (int i = 0; i < 8; i++) begin
      if (i % 2 == 0) send_req(sleep_item(8'($urandom), $urandom_range(1, 3)));
      else send_req(tick_item());
    end
  endtask

  // Mixed sleeps and ticks with short deadlines, plus occasional floods that fill the table.
  task automatic test_random_traffic();
    int unsigned counted;
    int unsigned pick;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_req(sleep_item(8'($urandom), 32'd0));
      end else if (pick < 9) begin
        while (sleeper_count < SLOTS) begin
          send_req(sleep_item(8'($urandom), $urandom_range(1, 12)));
          counted++;
        end
        send_req(sleep_item(8'($urandom), $urandom_range(1, 12)));
        counted++;
      end else if (pick < 55) begin
        send_req(sleep_item(8'($urandom), $urandom_range(1, 12)));
        counted++;
      end else begin
        send_req(tick_item());
        counted++;
      end
    end
  endtask

  // Receiver stall: a long hold when asked, otherwise a mode that changes now and then.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        mode_left  = $urandom_range(16, 80);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:     rsp_stall <= 1'b0;
        STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 2) == 0);
        default:        rsp_stall <= ((cycle_count % 5) < 2);
      endcase
    end
  end

  // Compare each response transfer with the oldest expected one.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_wakes.size() == 0) begin
        report_mismatch($sformatf("unexpected response task %0h", rsp.woken_task));
      end else begin
        want = pending_wakes.pop_front();
        if (rsp.woken_task !== want.woken_task)
          report_mismatch($sformatf("woken_task %0h, expected %0h",
                                    rsp.woken_task, want.woken_task));
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0b, expected %0b", rsp.status, want.status));
        if (rsp.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", rsp.last, want.last));
      end
    end
  end

  // Cycle counter with a hard limit on the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_tick();
    test_zero_ticks();
    test_wake_order();
    test_full_table();
    test_far_deadline();
    test_backpressure();
    test_random_traffic();
    wait_for_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/dst_pkg.sv
hw/rtl/dst_ctrl.sv
hw/rtl/dst_datapath.sv
hw/rtl/deadline_sleep_table.sv
sim/deadline_sleep_table_tb.sv
